@@ src/grouped_inode_bitmap_allocator_unit_assert.svh @@
// Assertion macros shared by the allocator RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GROUPED_INODE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define GROUPED_INODE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GIA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/gia_pkg.sv @@
// Shared types and constants of the grouped inode bitmap allocator.
// No dependencies.
package gia_pkg;

    localparam int WORD_W  = 32;
    localparam int CNT_W   = 9;
    localparam int TOT_W   = 13;
    localparam int ROTOR_W = 8;
    localparam int NUM_W   = 12;
    localparam int NE_W    = 9;
    localparam int NG_W    = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    // Row 0 holds numbers 0 and 1, which are in use after reset.
    localparam logic [WORD_W-1:0] ROW0_RESET = 32'h0000_0003;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [2:0] ST_OK             = 3'd0;
    localparam logic [2:0] ST_NOSPACE        = 3'd1;
    localparam logic [2:0] ST_PARENT_DELETED = 3'd2;
    localparam logic [2:0] ST_INVALID        = 3'd3;
    localparam logic [2:0] ST_ALREADY_FREE   = 3'd4;
    localparam logic [2:0] ST_CORRUPT        = 3'd5;

    localparam logic CFG_GROUPS  = 1'b0;
    localparam logic CFG_ENTRIES = 1'b1;

    typedef struct packed {
        logic               en;
        logic               alloc;
        logic               isdir;
        logic [ROTOR_W-1:0] offset;
    } grp_upd_t;

    typedef struct packed {
        logic [CNT_W-1:0]   free_cnt;
        logic [ROTOR_W-1:0] rotor;
        logic [TOT_W-1:0]   free_total;
        logic [TOT_W-1:0]   dir_total;
    } grp_rd_t;

endpackage

@@ src/grouped_inode_bitmap_allocator_unit.sv @@
// Grouped inode bitmap allocator: control sequencer, bitmap RAM and group table.
// Depends on gia_pkg, gia_ram, gia_div, gia_grp_tbl and the assertion header.
//
// Requests arrive on the s_ channel: tuser is the function (0 allocate, 1 free),
// tdata carries the number, the directory flag and the parent-linked flag.
// Each request yields exactly one response on the m_ channel: tuser is the
// status, tdata the allocated number and the free and directory totals.
// The bitmap lives in a RAM of 32-bit rows, MAX_GROUPS * ceil(MAX_PER_GROUP/32)
// rows deep; per-row valid flops make a never-written row read as its reset
// value, so no clearing pass runs after reset.
// One request is processed at a time. A refused parent or an invalid number
// goes straight to the final state, with no divide. A free takes a divide of
// the number by the group size, one RAM read, one write-back and a load of the
// output register. An allocate adds a second divide for the parent group,
// probes one group per cycle (at most 19 with 16 groups), and spends a read
// state and an evaluate state on each bitmap row scanned (up to 2 * rows per
// group when the search wraps). Reset clears all counts to their initial
// values and empties the output. If the receiver stalls, the finished response
// waits in the output register; the next request is accepted meanwhile, and
// its response waits until the register drains. Configuration is to be written
// with cfg_we only while idle; the block itself does not enforce this.
`include "grouped_inode_bitmap_allocator_unit_assert.svh"

module grouped_inode_bitmap_allocator_unit #(
    parameter int MAX_GROUPS    = 16,
    parameter int MAX_PER_GROUP = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] inode_number, [12] dir_flag, [13] parent_linked
    input  logic [15:0] s_tdata,
    // [0] func
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [11:0] allocated_number, [24:12] total_free, [37:25] total_directories
    output logic [39:0] m_tdata,
    // [2:0] status
    output logic [2:0]  m_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int WW   = gia_pkg::WORD_W;
    localparam int RPG  = (MAX_PER_GROUP + WW - 1) / WW;
    localparam int ROWS = MAX_GROUPS * RPG;
    localparam int AW   = ROWS > 1 ? $clog2(ROWS) : 1;
    localparam int RW   = RPG > 1 ? $clog2(RPG) : 1;
    localparam int GCW  = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
    localparam int GIW  = $clog2(MAX_GROUPS + 2);
    localparam int JW   = GIW + 1;
    localparam int KW   = $clog2(WW);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DIV1    = 4'd1;
    localparam logic [3:0] S_DIV2    = 4'd2;
    localparam logic [3:0] S_PROBE   = 4'd3;
    localparam logic [3:0] S_SCAN_RD = 4'd4;
    localparam logic [3:0] S_SCAN_EV = 4'd5;
    localparam logic [3:0] S_FREE_EV = 4'd6;
    localparam logic [3:0] S_FIN     = 4'd7;

    // Configuration registers.
    logic [gia_pkg::NG_W-1:0] groups_reg;
    logic [gia_pkg::NE_W-1:0] entries_reg;
    logic [GIW-1:0]           ng;
    logic [gia_pkg::NE_W-1:0] ne;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_reg  <= gia_pkg::NG_W'(16);
            entries_reg <= gia_pkg::NE_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gia_pkg::CFG_GROUPS:  groups_reg  <= cfg_data[gia_pkg::NG_W-1:0];
                gia_pkg::CFG_ENTRIES: entries_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (groups_reg == '0)
        begin
            ng = GIW'(1);
        end
        else if (int'(groups_reg) > MAX_GROUPS)
        begin
            ng = GIW'(MAX_GROUPS);
        end
        else
        begin
            ng = GIW'(groups_reg);
        end
        if (entries_reg < gia_pkg::NE_W'(2))
        begin
            ne = gia_pkg::NE_W'(2);
        end
        else if (int'(entries_reg) > MAX_PER_GROUP)
        begin
            ne = gia_pkg::NE_W'(MAX_PER_GROUP);
        end
        else
        begin
            ne = entries_reg;
        end
    end

    // Sequencer state.
    logic [3:0]                 state_reg, state_next;
    logic                       func_reg, func_next;
    logic                       isdir_reg, isdir_next;
    logic [2:0]                 status_reg, status_next;
    logic [gia_pkg::NUM_W-1:0]  alloc_reg, alloc_next;
    logic [GCW-1:0]             cg_reg, cg_next;
    logic [gia_pkg::NE_W-1:0]   bit_reg, bit_next;
    logic [GIW-1:0]             pg_reg, pg_next;
    logic [GIW-1:0]             cur_reg, cur_next;
    logic [JW-1:0]              j_reg, j_next;
    logic                       lin_reg, lin_next;
    logic [gia_pkg::ROTOR_W-1:0] start_reg, start_next;
    logic [RW-1:0]              row_reg, row_next;
    logic                       pass1_reg, pass1_next;
    logic [AW-1:0]              rd_row_reg;

    // Output register.
    logic                       m_tvalid_reg;
    logic [2:0]                 m_status_reg;
    logic [gia_pkg::NUM_W-1:0]  m_alloc_reg;
    logic [gia_pkg::TOT_W-1:0]  m_ftot_reg, m_dtot_reg;
    logic                       out_load;

    // Divider.
    logic                       div_start, div_done;
    logic [gia_pkg::NUM_W-1:0]  div_dividend, div_quot;
    logic [gia_pkg::NE_W-1:0]   div_divisor, div_rem;

    // RAM.
    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [WW-1:0]              ram_wdata, ram_rdata;
    logic [ROWS-1:0]            row_valid_reg;

    // Group table.
    gia_pkg::grp_upd_t          upd;
    gia_pkg::grp_rd_t           grp;
    logic [GCW-1:0]             tbl_idx;

    // Scan helpers.
    logic [WW-1:0]              word, cand;
    logic                       hit;
    logic [KW-1:0]              hit_k;
    logic [gia_pkg::NE_W-1:0]   lim;
    logic [RW-1:0]              last_row;
    logic [gia_pkg::NE_W-1:0]   ne_m1;
    logic [gia_pkg::NE_W-1:0]   hit_bit;
    logic [13:0]                span;
    logic [JW:0]                qsum;
    logic [GIW:0]               lsum;
    logic [GIW:0]               pg2;
    logic [12:0]                num_full;
    logic [KW-1:0]              free_k;

    function automatic logic [AW-1:0] row_addr(input logic [GCW-1:0] g,
                                               input logic [RW-1:0] r);
        row_addr = AW'(AW'(g) * AW'(RPG) + AW'(r));
    endfunction

    assign word = row_valid_reg[rd_row_reg] ? ram_rdata
                  : ((rd_row_reg == '0) ? gia_pkg::ROW0_RESET : '0);

    assign lim      = (gia_pkg::NE_W'(start_reg) < ne) ? gia_pkg::NE_W'(start_reg) : ne;
    assign ne_m1    = ne - gia_pkg::NE_W'(1);
    assign last_row = RW'(ne_m1 >> KW);
    assign span     = 14'(ng) * 14'(ne);

    // Bits of the current row that are clear and lie in the current search window.
    always_comb
    begin
        logic [12:0] pos;
        cand = '0;
        for (int k = 0; k < WW; k++)
        begin
            pos = (13'(row_reg) << KW) | 13'(k);
            if (pass1_reg)
            begin
                cand[k] = !word[k] && (pos >= 13'(start_reg)) && (pos < 13'(ne));
            end
            else
            begin
                cand[k] = !word[k] && (pos < 13'(lim));
            end
        end
    end

    always_comb
    begin
        hit_k = '0;
        for (int k = WW - 1; k >= 0; k--)
        begin
            if (cand[k])
            begin
                hit_k = KW'(k);
            end
        end
    end

    assign hit      = |cand;
    assign hit_bit  = gia_pkg::NE_W'((13'(row_reg) << KW) | 13'(hit_k));
    assign free_k   = bit_reg[KW-1:0];
    assign qsum     = (JW+1)'(cur_reg) + (JW+1)'(j_reg);
    assign lsum     = (GIW+1)'(cur_reg) + (GIW+1)'(1);
    assign pg2      = (GIW+1)'(pg_reg) + (GIW+1)'(2);
    assign num_full = 13'(alloc_reg);
    assign tbl_idx  = (state_reg == S_PROBE) ? cur_reg[GCW-1:0] : cg_reg;
    assign out_load = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        isdir_next   = isdir_reg;
        status_next  = status_reg;
        alloc_next   = alloc_reg;
        cg_next      = cg_reg;
        bit_next     = bit_reg;
        pg_next      = pg_reg;
        cur_next     = cur_reg;
        j_next       = j_reg;
        lin_next     = lin_reg;
        start_next   = start_reg;
        row_next     = row_reg;
        pass1_next   = pass1_reg;
        div_start    = 1'b0;
        div_dividend = s_tdata[gia_pkg::NUM_W-1:0];
        div_divisor  = ne;
        ram_re       = 1'b0;
        ram_raddr    = row_addr(cg_reg, row_reg);
        ram_we       = 1'b0;
        ram_waddr    = row_addr(cg_reg, row_reg);
        ram_wdata    = word;
        upd          = '0;
        upd.isdir    = isdir_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next   = s_tuser;
                    isdir_next  = s_tdata[12];
                    status_next = gia_pkg::ST_OK;
                    alloc_next  = '0;
                    if (s_tuser == gia_pkg::FUNC_ALLOC && !s_tdata[13])
                    begin
                        status_next = gia_pkg::ST_PARENT_DELETED;
                        state_next  = S_FIN;
                    end
                    else if (s_tuser == gia_pkg::FUNC_FREE &&
                             !(s_tdata[11:0] > 12'd1 && 14'(s_tdata[11:0]) < span))
                    begin
                        status_next = gia_pkg::ST_INVALID;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV1;
                    end
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    if (func_reg == gia_pkg::FUNC_FREE)
                    begin
                        cg_next    = div_quot[GCW-1:0];
                        bit_next   = div_rem;
                        ram_re     = 1'b1;
                        ram_raddr  = row_addr(div_quot[GCW-1:0], RW'(div_rem >> KW));
                        state_next = S_FREE_EV;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = div_quot;
                        div_divisor  = gia_pkg::NE_W'(ng);
                        state_next   = S_DIV2;
                    end
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    pg_next    = GIW'(div_rem);
                    cur_next   = GIW'(div_rem);
                    j_next     = JW'(1);
                    lin_next   = 1'b0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (grp.free_cnt != '0)
                begin
                    cg_next    = cur_reg[GCW-1:0];
                    start_next = grp.rotor;
                    // A rotor at or past the group size leaves only the wrap pass.
                    if (gia_pkg::NE_W'(grp.rotor) < ne)
                    begin
                        pass1_next = 1'b1;
                        row_next   = RW'(grp.rotor >> KW);
                    end
                    else
                    begin
                        pass1_next = 1'b0;
                        row_next   = '0;
                    end
                    state_next = S_SCAN_RD;
                end
                else if (!lin_reg)
                begin
                    if (j_reg < JW'(ng))
                    begin
                        cur_next = (qsum >= (JW+1)'(ng)) ? GIW'(qsum - (JW+1)'(ng))
                                                         : GIW'(qsum);
                        j_next   = j_reg << 1;
                    end
                    else if (JW'(2) < JW'(ng))
                    begin
                        cur_next = (pg2 >= (GIW+1)'(ng)) ? '0 : GIW'(pg2);
                        j_next   = JW'(2);
                        lin_next = 1'b1;
                    end
                    else
                    begin
                        status_next = gia_pkg::ST_NOSPACE;
                        state_next  = S_FIN;
                    end
                end
                else
                begin
                    if (j_reg + JW'(1) < JW'(ng))
                    begin
                        cur_next = (lsum >= (GIW+1)'(ng)) ? '0 : GIW'(lsum);
                        j_next   = j_reg + JW'(1);
                    end
                    else
                    begin
                        status_next = gia_pkg::ST_NOSPACE;
                        state_next  = S_FIN;
                    end
                end
            end
            S_SCAN_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                if (hit)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = word | (WW'(1) << hit_k);
                    upd.en     = 1'b1;
                    upd.alloc  = 1'b1;
                    alloc_next = gia_pkg::NUM_W'(13'(cg_reg) * 13'(ne) + 13'(hit_bit));
                    state_next = S_FIN;
                end
                else if (row_reg == last_row)
                begin
                    if (pass1_reg)
                    begin
                        pass1_next = 1'b0;
                        row_next   = '0;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        status_next = gia_pkg::ST_CORRUPT;
                        state_next  = S_FIN;
                    end
                end
                else
                begin
                    row_next   = row_reg + RW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_FREE_EV:
            begin
                if (!word[free_k])
                begin
                    status_next = gia_pkg::ST_ALREADY_FREE;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = rd_row_reg;
                    ram_wdata  = word & ~(WW'(1) << free_k);
                    upd.en     = 1'b1;
                    upd.alloc  = 1'b0;
                    upd.offset = bit_reg[gia_pkg::ROTOR_W-1:0];
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                row_valid_reg[ram_waddr] <= 1'b1;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        isdir_reg  <= isdir_next;
        status_reg <= status_next;
        alloc_reg  <= alloc_next;
        cg_reg     <= cg_next;
        bit_reg    <= bit_next;
        pg_reg     <= pg_next;
        cur_reg    <= cur_next;
        j_reg      <= j_next;
        lin_reg    <= lin_next;
        start_reg  <= start_next;
        row_reg    <= row_next;
        pass1_reg  <= pass1_next;
        if (ram_re)
        begin
            rd_row_reg <= ram_raddr;
        end
        if (out_load)
        begin
            m_status_reg <= status_reg;
            m_alloc_reg  <= num_full[gia_pkg::NUM_W-1:0];
            m_ftot_reg   <= grp.free_total;
            m_dtot_reg   <= grp.dir_total;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_dtot_reg, m_ftot_reg, m_alloc_reg};

    gia_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    gia_ram #(
        .WIDTH (WW),
        .DEPTH (ROWS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gia_grp_tbl #(
        .MAX_GROUPS    (MAX_GROUPS),
        .MAX_PER_GROUP (MAX_PER_GROUP)
    ) u_grp_tbl (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (tbl_idx),
        .upd   (upd),
        .rd    (grp)
    );

    `GIA_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg != S_IDLE, "accept left idle")
    `GIA_ASSERT_IMP(a_div_state, div_done, state_reg == S_DIV1 || state_reg == S_DIV2, "stray divide")
    `GIA_ASSERT_NEXT(a_row_valid, ram_we, row_valid_reg[$past(ram_waddr)], "row not marked valid")

endmodule

@@ src/gia_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module gia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/gia_div.sv @@
// Restoring divider, one quotient bit per cycle, for the number split.
// Depends on gia_pkg.
module gia_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gia_pkg::NUM_W-1:0]  dividend,
    input  logic [gia_pkg::NE_W-1:0]   divisor,
    output logic                       done,
    output logic [gia_pkg::NUM_W-1:0]  quot,
    output logic [gia_pkg::NE_W-1:0]   rem
);

    localparam int CW = $clog2(gia_pkg::NUM_W + 1);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [gia_pkg::NUM_W-1:0] q_reg, q_next;
    logic [gia_pkg::NE_W-1:0]  r_reg, r_next;
    logic [gia_pkg::NE_W-1:0]  d_reg, d_next;
    logic [gia_pkg::NE_W:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg, q_reg[gia_pkg::NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(gia_pkg::NUM_W);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits NE_W bits.
            if (trial >= {1'b0, d_reg})
            begin
                r_next = gia_pkg::NE_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[gia_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[gia_pkg::NE_W-1:0];
                q_next = {q_reg[gia_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

@@ src/gia_grp_tbl.sv @@
// Per-group free counts, directory counts and rotors, plus the two totals.
// Depends on gia_pkg.
module gia_grp_tbl #(
    parameter int MAX_GROUPS    = 16,
    parameter int MAX_PER_GROUP = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [(MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1)-1:0] idx,
    input  gia_pkg::grp_upd_t   upd,
    output gia_pkg::grp_rd_t    rd
);

    localparam int FULL = MAX_PER_GROUP > int'(gia_pkg::CNT_MAX)
                          ? int'(gia_pkg::CNT_MAX) : MAX_PER_GROUP;
    localparam int G0 = (MAX_PER_GROUP - 2) > int'(gia_pkg::CNT_MAX)
                        ? int'(gia_pkg::CNT_MAX) : (MAX_PER_GROUP - 2);
    localparam int FT = (MAX_GROUPS * MAX_PER_GROUP - 2) > int'(gia_pkg::TOT_MAX)
                        ? int'(gia_pkg::TOT_MAX) : (MAX_GROUPS * MAX_PER_GROUP - 2);

    logic [gia_pkg::CNT_W-1:0]   free_reg  [MAX_GROUPS];
    logic [gia_pkg::CNT_W-1:0]   dir_reg   [MAX_GROUPS];
    logic [gia_pkg::ROTOR_W-1:0] rotor_reg [MAX_GROUPS];
    logic [gia_pkg::TOT_W-1:0]   ftot_reg, ftot_next;
    logic [gia_pkg::TOT_W-1:0]   dtot_reg, dtot_next;
    logic [gia_pkg::CNT_W-1:0]   free_next, dir_next;
    logic [gia_pkg::ROTOR_W-1:0] rotor_next;
    logic [gia_pkg::CNT_W-1:0]   free_cur, dir_cur;
    logic [gia_pkg::ROTOR_W-1:0] rotor_cur;

    assign free_cur  = free_reg[idx];
    assign dir_cur   = dir_reg[idx];
    assign rotor_cur = rotor_reg[idx];

    always_comb
    begin
        free_next  = free_cur;
        dir_next   = dir_cur;
        rotor_next = rotor_cur;
        ftot_next  = ftot_reg;
        dtot_next  = dtot_reg;
        if (upd.alloc)
        begin
            free_next = (free_cur == '0) ? '0 : free_cur - 1'b1;
            ftot_next = (ftot_reg == '0) ? '0 : ftot_reg - 1'b1;
            if (upd.isdir)
            begin
                dir_next  = (dir_cur == gia_pkg::CNT_MAX) ? dir_cur : dir_cur + 1'b1;
                dtot_next = (dtot_reg == gia_pkg::TOT_MAX) ? dtot_reg : dtot_reg + 1'b1;
            end
        end
        else
        begin
            free_next = (free_cur == gia_pkg::CNT_MAX) ? free_cur : free_cur + 1'b1;
            ftot_next = (ftot_reg == gia_pkg::TOT_MAX) ? ftot_reg : ftot_reg + 1'b1;
            if (upd.offset < rotor_cur)
            begin
                rotor_next = upd.offset;
            end
            if (upd.isdir)
            begin
                dir_next  = (dir_cur == '0) ? '0 : dir_cur - 1'b1;
                dtot_next = (dtot_reg == '0) ? '0 : dtot_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < MAX_GROUPS; g++)
            begin
                free_reg[g]  <= (g == 0) ? gia_pkg::CNT_W'(G0) : gia_pkg::CNT_W'(FULL);
                dir_reg[g]   <= '0;
                rotor_reg[g] <= '0;
            end
            ftot_reg <= gia_pkg::TOT_W'(FT);
            dtot_reg <= '0;
        end
        else if (upd.en)
        begin
            free_reg[idx]  <= free_next;
            dir_reg[idx]   <= dir_next;
            rotor_reg[idx] <= rotor_next;
            ftot_reg       <= ftot_next;
            dtot_reg       <= dtot_next;
        end
    end

    assign rd.free_cnt   = free_cur;
    assign rd.rotor      = rotor_cur;
    assign rd.free_total = ftot_reg;
    assign rd.dir_total  = dtot_reg;

endmodule

@@ bench/grouped_inode_bitmap_allocator_unit_tb.sv @@
// Testbench for the grouped inode bitmap allocator: directed and random requests,
// checked against a predictor of the allocator state. Depends on gia_pkg and the RTL.
module grouped_inode_bitmap_allocator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NGRP = 16;
    localparam int NPER = 256;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [2:0]                status;
        logic [gia_pkg::NUM_W-1:0] alloc_num;
        logic [gia_pkg::TOT_W-1:0] free_tot;
        logic [gia_pkg::TOT_W-1:0] dir_tot;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    // Shadow of the allocator state.
    bit          used_map[NGRP][NPER];
    int unsigned grp_free[NGRP];
    int unsigned grp_dirs[NGRP];
    int unsigned grp_rotor[NGRP];
    int unsigned free_count;
    int unsigned dir_count;
    logic [4:0]  groups_reg;
    logic [8:0]  entries_reg;

    alloc_result_t pending_results[$];
    int            live_numbers[$];
    int            mismatches;
    int            cycle_count;
    bit            hold_request;

    grouped_inode_bitmap_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned active_groups();
        if (groups_reg < 1) return 1;
        if (groups_reg > NGRP) return NGRP;
        return groups_reg;
    endfunction

    function automatic int unsigned active_entries();
        if (entries_reg < 2) return 2;
        if (entries_reg > NPER) return NPER;
        return entries_reg;
    endfunction

    task automatic reset_shadow();
        foreach (used_map[g, b]) used_map[g][b] = 1'b0;
        used_map[0][0] = 1'b1;
        used_map[0][1] = 1'b1;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_free[g] = (g == 0) ? NPER - 2 : NPER;
            grp_dirs[g] = 0;
            grp_rotor[g] = 0;
        end
        free_count = NGRP * NPER - 2;
        dir_count = 0;
        groups_reg = 5'd16;
        entries_reg = 9'd256;
    endtask

    // Parent group first, then a probe with doubling steps, then a linear sweep.
    function automatic int unsigned choose_group(int unsigned pg, int unsigned ng);
        int unsigned i;
        i = pg;
        if (grp_free[i] != 0) return i;
        for (int unsigned j = 1; j < ng; j = j << 1)
        begin
            i += j;
            if (i >= ng) i -= ng;
            if (grp_free[i] != 0) return i;
        end
        i = pg + 1;
        for (int unsigned j = 2; j < ng; j++)
        begin
            i++;
            if (i >= ng) i = 0;
            if (grp_free[i] != 0) return i;
        end
        return ng;
    endfunction

    task automatic predict_request(input logic func, input logic [gia_pkg::NUM_W-1:0] num,
                                   input logic isdir, input logic linked,
                                   output alloc_result_t res);
        int unsigned ng, ne, cg, bitpos, start, lim;
        ng = active_groups();
        ne = active_entries();
        res.status = gia_pkg::ST_OK;
        res.alloc_num = '0;
        if (func == gia_pkg::FUNC_ALLOC)
        begin
            if (!linked)
                res.status = gia_pkg::ST_PARENT_DELETED;
            else
            begin
                cg = choose_group((num / ne) % ng, ng);
                if (cg >= ng)
                    res.status = gia_pkg::ST_NOSPACE;
                else
                begin
                    start = grp_rotor[cg];
                    lim = (start < ne) ? start : ne;
                    bitpos = ne;
                    for (int unsigned b = start; b < ne; b++)
                        if (!used_map[cg][b])
                        begin
                            bitpos = b;
                            break;
                        end
                    if (bitpos >= ne)
                        for (int unsigned b = 0; b < lim; b++)
                            if (!used_map[cg][b])
                            begin
                                bitpos = b;
                                break;
                            end
                    if (bitpos >= ne)
                        res.status = gia_pkg::ST_CORRUPT;
                    else
                    begin
                        used_map[cg][bitpos] = 1'b1;
                        if (grp_free[cg] != 0) grp_free[cg]--;
                        if (free_count != 0) free_count--;
                        if (isdir)
                        begin
                            if (grp_dirs[cg] < gia_pkg::CNT_MAX) grp_dirs[cg]++;
                            if (dir_count < gia_pkg::TOT_MAX) dir_count++;
                        end
                        res.alloc_num = gia_pkg::NUM_W'(cg * ne + bitpos);
                    end
                end
            end
        end
        else if (!(num > 1 && num < ng * ne))
            res.status = gia_pkg::ST_INVALID;
        else
        begin
            cg = num / ne;
            bitpos = num % ne;
            if (!used_map[cg][bitpos])
                res.status = gia_pkg::ST_ALREADY_FREE;
            else
            begin
                used_map[cg][bitpos] = 1'b0;
                if (bitpos < grp_rotor[cg]) grp_rotor[cg] = bitpos;
                if (grp_free[cg] < gia_pkg::CNT_MAX) grp_free[cg]++;
                if (free_count < gia_pkg::TOT_MAX) free_count++;
                if (isdir)
                begin
                    if (grp_dirs[cg] != 0) grp_dirs[cg]--;
                    if (dir_count != 0) dir_count--;
                end
            end
        end
        res.free_tot = gia_pkg::TOT_W'(free_count);
        res.dir_tot = gia_pkg::TOT_W'(dir_count);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    task automatic send_request(input logic func, input logic [gia_pkg::NUM_W-1:0] num,
                                input logic isdir, input logic linked, input bit no_gap = 0);
        int gap;
        alloc_result_t res;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {2'b00, linked, isdir, num};
        do
            @(posedge clk);
        while (!s_tready);
        predict_request(func, num, isdir, linked, res);
        pending_results.push_back(res);
        if (func == gia_pkg::FUNC_ALLOC && res.status == gia_pkg::ST_OK)
            live_numbers.push_back(res.alloc_num);
    endtask

    task automatic end_stream();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits for the block to drain, then writes one register.
    task automatic write_register(input logic idx, input logic [8:0] value);
        end_stream();
        wait (pending_results.size() == 0);
        repeat (80) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == gia_pkg::CFG_GROUPS)
            groups_reg = value[4:0];
        else
            entries_reg = value;
    endtask

    task automatic set_geometry(input logic [8:0] groups, input logic [8:0] entries);
        write_register(gia_pkg::CFG_GROUPS, groups);
        write_register(gia_pkg::CFG_ENTRIES, entries);
    endtask

    // Receiver: random stalls, ready runs, and a long hold-off on request.
    initial
    begin
        int r, len;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45) begin m_tready <= 1'b1; len = $urandom_range(1, 8); end
                else if (r < 60) begin m_tready <= 1'b1; len = $urandom_range(40, 150); end
                else if (r < 95) begin m_tready <= 1'b0; len = $urandom_range(1, 4); end
                else begin m_tready <= 1'b0; len = $urandom_range(20, 80); end
                repeat (len - 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected response: status %0d number %0d", m_tuser,
                             m_tdata[11:0]);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status || m_tdata[11:0] !== want.alloc_num
                    || m_tdata[24:12] !== want.free_tot || m_tdata[37:25] !== want.dir_tot)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: expected st %0d num %0d free %0d dir %0d,",
                                 want.status, want.alloc_num, want.free_tot, want.dir_tot);
                        $display("          got st %0d num %0d free %0d dir %0d",
                                 m_tuser, m_tdata[11:0], m_tdata[24:12], m_tdata[37:25]);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_directed_edges();
        send_request(gia_pkg::FUNC_FREE, 12'd0, 1'b0, 1'b1);
        send_request(gia_pkg::FUNC_FREE, 12'd1, 1'b1, 1'b0);
        send_request(gia_pkg::FUNC_FREE, 12'd4095, 1'b1, 1'b1);
        send_request(gia_pkg::FUNC_ALLOC, 12'd4095, 1'b1, 1'b0);
        send_request(gia_pkg::FUNC_ALLOC, 12'd4095, 1'b1, 1'b1);
        send_request(gia_pkg::FUNC_ALLOC, 12'd0, 1'b0, 1'b1);
        send_request(gia_pkg::FUNC_ALLOC, 12'd0, 1'b1, 1'b1);
        send_request(gia_pkg::FUNC_FREE, 12'd3840, 1'b1, 1'b1);
        send_request(gia_pkg::FUNC_FREE, 12'd2, 1'b0, 1'b1);
        send_request(gia_pkg::FUNC_FREE, 12'd2, 1'b0, 1'b1);
        send_request(gia_pkg::FUNC_ALLOC, 12'd2, 1'b0, 1'b1);
    endtask

    // Clamped extremes of both registers, including a stale count with a full group.
    task automatic test_config_extremes();
        set_geometry(9'd31, 9'd511);
        send_request(gia_pkg::FUNC_ALLOC, 12'd4095, 1'b0, 1'b1);
        send_request(gia_pkg::FUNC_FREE, 12'd4095, 1'b0, 1'b1);
        set_geometry(9'd0, 9'd0);
        send_request(gia_pkg::FUNC_ALLOC, 12'd4095, 1'b1, 1'b1);
        send_request(gia_pkg::FUNC_FREE, 12'd2, 1'b0, 1'b1);
        send_request(gia_pkg::FUNC_FREE, 12'd1, 1'b0, 1'b1);
        set_geometry(9'd2, 9'd1);
        send_request(gia_pkg::FUNC_ALLOC, 12'd3, 1'b1, 1'b1);
        send_request(gia_pkg::FUNC_ALLOC, 12'd3, 1'b0, 1'b1);
        send_request(gia_pkg::FUNC_FREE, 12'd3, 1'b1, 1'b1);
        send_request(gia_pkg::FUNC_ALLOC, 12'd2, 1'b0, 1'b1);
    endtask

    // One group filled until the allocator reports no space.
    task automatic test_fill_group();
        set_geometry(9'd1, 9'd256);
        while (grp_free[0] != 0)
            send_request(gia_pkg::FUNC_ALLOC, 12'($urandom), 1'($urandom), 1'b1, 1'b1);
        send_request(gia_pkg::FUNC_ALLOC, 12'd100, 1'b0, 1'b1);
        send_request(gia_pkg::FUNC_FREE, 12'd77, 1'b0, 1'b1);
        send_request(gia_pkg::FUNC_ALLOC, 12'd3000, 1'b0, 1'b1);
    endtask

    task automatic random_request();
        int r, idx;
        r = $urandom_range(0, 99);
        if (r < 50)
            send_request(gia_pkg::FUNC_ALLOC, 12'($urandom), 1'($urandom), 1'b1);
        else if (r < 85 && live_numbers.size() > 0)
        begin
            idx = $urandom_range(0, live_numbers.size() - 1);
            send_request(gia_pkg::FUNC_FREE, 12'(live_numbers[idx]), 1'($urandom), 1'b1);
            live_numbers.delete(idx);
        end
        else
            send_request(1'($urandom), 12'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic test_random_phase(input logic [8:0] groups, input logic [8:0] entries,
                                     input int count);
        set_geometry(groups, entries);
        repeat (count) random_request();
    endtask

    // Receiver holds off while requests keep coming, so the input stalls.
    task automatic test_backpressure();
        end_stream();
        wait (pending_results.size() == 0);
        hold_request = 1'b1;
        repeat (12) random_request();
        end_stream();
        wait (pending_results.size() == 0);
        repeat (10) random_request();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        cycle_count = 0;
        hold_request = 1'b0;
        reset_shadow();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_config_extremes();
        test_fill_group();
        live_numbers.delete();
        test_random_phase(9'd16, 9'd256, 40);
        test_backpressure();
        test_random_phase(9'd4, 9'd32, 30);
        test_random_phase(9'd5, 9'd9, 30);
        test_random_phase(9'd16, 9'd17, 25);
        test_random_phase(9'd31, 9'd511, 25);

        end_stream();
        wait (pending_results.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
